// ===== design/hem_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall encoder RPM meter package
// Shared types, codes and widths of the hall encoder speed meter.
// ----------------------------------------------------------------------------
package hem_pkg;

	localparam int TIME_W     = 32;
	localparam int CFG_W      = 24;
	localparam int COUNT_W    = 16;
	localparam int SPEED_W    = 24;
	localparam int DIVIDEND_W = COUNT_W + CFG_W;
	localparam int DIVISOR_W  = CFG_W;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
	localparam int CFG_IDX_W  = 2;

	// Event kinds.
	localparam logic [1:0] KIND_H1_RISE = 2'd0;
	localparam logic [1:0] KIND_H2_FALL = 2'd1;
	localparam logic [1:0] KIND_QUERY   = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MOTOR_REVERSED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WINDOW     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE    = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] MIN_WINDOW_RST  = 24'd50000;
	localparam logic [CFG_W-1:0] MAX_WINDOW_RST  = 24'd1000000;
	localparam logic [CFG_W-1:0] SPEED_SCALE_RST = 24'd1777778;

	// Saturation limits of the signed speed.
	localparam logic [DIVIDEND_W-1:0] SPEED_POS_MAX = 40'd8388607;
	localparam logic [DIVIDEND_W-1:0] SPEED_NEG_MAG = 40'd8388608;

	typedef struct packed {
		logic             motor_reversed;
		logic [CFG_W-1:0] min_window_us;
		logic [CFG_W-1:0] max_window_us;
		logic [CFG_W-1:0] speed_scale;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EVAL  = 5'b00010,
		ST_START = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

endpackage

// ===== design/hall_encoder_rpm_meter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall encoder RPM meter
// Speed and direction meter for one wheel with a two-channel hall encoder.
// ----------------------------------------------------------------------------
// Usage: one instance per wheel. Each input transfer (in_valid high, in_stall
// low) carries one event: an H1 rising edge, an H2 falling edge with the H1
// level, or a speed query, each stamped with a free-running microsecond time.
// Every event yields exactly one output transfer (out_valid high, out_stall
// low) with the speed in Q4 rpm and the current direction.
// The config port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready
// and should only be written while no event is in flight.
// Sequence: an event that closes a speed window with a computed speed passes
// through ST_EVAL, ST_START, ST_DIV and ST_DONE; the 40-bit restoring divider,
// one quotient bit per cycle, runs in ST_DIV. Every other event goes from
// ST_EVAL straight to ST_DONE. One event is processed at a time and in_stall
// stays high while busy, so the next event is taken only back in ST_IDLE.
// The result sits in an output register, so the next event can be taken
// while the previous result still waits; if the receiver stalls a second
// finished result, the block holds it and keeps in_stall high until the
// first one is taken.
// Reset: asynchronous, active low. Speed zero, direction forward, window
// start zero, count zero, and the config registers take their defaults.
// ----------------------------------------------------------------------------
module hall_encoder_rpm_meter_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// Event channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     kind,
	input  logic [hem_pkg::TIME_W-1:0]     now_us,
	input  logic                           h1_level,
	// Result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [hem_pkg::SPEED_W-1:0] speed_q4,
	output logic                           forward,
	// Configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hem_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hem_pkg::CFG_W-1:0]      cfg_data
);
	import hem_pkg::*;

	cfg_t   cfg;
	state_t state_q;

	// Captured event.
	logic [1:0]        kind_q;
	logic [TIME_W-1:0] now_q;
	logic              h1_q;

	// Meter state.
	logic [COUNT_W-1:0] count_q;
	logic [TIME_W-1:0]  wstart_q;
	logic               fwd_q;
	logic [SPEED_W-1:0] speed_q;

	// Operands of the speed computation.
	logic [COUNT_W-1:0]   cnt_op_q;
	logic [DIVISOR_W-1:0] len_q;
	logic                 neg_q;

	// Output register.
	logic               out_valid_q;
	logic [SPEED_W-1:0] speed_out_q;
	logic               fwd_out_q;

	logic [TIME_W-1:0]     len;
	logic                  len_zero;
	logic                  below_min;
	logic                  above_max;
	logic [COUNT_W-1:0]    cnt_inc;
	logic [DIVIDEND_W-1:0] product;
	logic                  div_start;
	logic                  div_done;
	logic [DIVIDEND_W-1:0] quotient;
	logic [SPEED_W-1:0]    speed_new;
	logic                  in_xfer;
	logic                  out_free;

	hem_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Window length wraps with the timestamp.
	assign len       = now_q - wstart_q;
	assign len_zero  = (len == '0);
	assign below_min = len < TIME_W'(cfg.min_window_us);
	assign above_max = len > TIME_W'(cfg.max_window_us);
	assign cnt_inc   = (count_q == '1) ? count_q : count_q + 1'b1;

	// 16 x 24 product feeds the divider's load register directly.
	assign product   = DIVIDEND_W'(cnt_op_q) * DIVIDEND_W'(cfg.speed_scale);
	assign div_start = (state_q == ST_START);

	hem_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (len_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Clamp the magnitude and apply the sign.
	always_comb begin
		if (neg_q) begin
			if (quotient > SPEED_NEG_MAG) begin
				speed_new = SPEED_NEG_MAG[SPEED_W-1:0];
			end else begin
				speed_new = SPEED_W'(0) - quotient[SPEED_W-1:0];
			end
		end else begin
			if (quotient > SPEED_POS_MAX) begin
				speed_new = SPEED_POS_MAX[SPEED_W-1:0];
			end else begin
				speed_new = quotient[SPEED_W-1:0];
			end
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q <= kind;
			now_q  <= now_us;
			h1_q   <= h1_level;
		end
	end

	// Sequencer and meter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			wstart_q <= '0;
			fwd_q    <= 1'b1;
			speed_q  <= '0;
			cnt_op_q <= '0;
			len_q    <= '0;
			neg_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q  <= ST_DONE;
					len_q    <= len[DIVISOR_W-1:0];
					neg_q    <= !fwd_q ^ cfg.motor_reversed;
					unique case (kind_q)
						KIND_H1_RISE: begin
							if (len_zero || below_min) begin
								count_q <= cnt_inc;
							end else if (above_max) begin
								speed_q  <= '0;
								wstart_q <= now_q;
								count_q  <= '0;
							end else begin
								cnt_op_q <= cnt_inc;
								state_q  <= ST_START;
							end
						end
						KIND_H2_FALL: begin
							if (h1_q != fwd_q) begin
								// A direction change closes the window at once.
								if (len_zero) begin
									count_q <= '0;
									fwd_q   <= h1_q;
								end else if (above_max) begin
									speed_q  <= '0;
									wstart_q <= now_q;
									count_q  <= '0;
									fwd_q    <= h1_q;
								end else begin
									cnt_op_q <= count_q;
									state_q  <= ST_START;
								end
							end
						end
						KIND_QUERY: begin
							if (above_max) begin
								speed_q <= '0;
							end
						end
						default: ;
					endcase
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						speed_q  <= speed_new;
						wstart_q <= now_q;
						count_q  <= '0;
						if (kind_q == KIND_H2_FALL) begin
							fwd_q <= h1_q;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: loaded when a result is done and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			speed_out_q <= speed_q;
			fwd_out_q   <= fwd_q;
		end
	end

	assign out_valid = out_valid_q;
	assign speed_q4  = speed_out_q;
	assign forward   = fwd_out_q;

endmodule

// ===== design/hem_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall encoder RPM meter configuration registers
// Holds the four configuration registers written through the config port.
// ----------------------------------------------------------------------------
module hem_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hem_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hem_pkg::CFG_W-1:0]      cfg_data,
	output hem_pkg::cfg_t                  cfg
);
	import hem_pkg::*;

	cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.motor_reversed <= 1'b0;
			cfg_q.min_window_us  <= MIN_WINDOW_RST;
			cfg_q.max_window_us  <= MAX_WINDOW_RST;
			cfg_q.speed_scale    <= SPEED_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MOTOR_REVERSED: cfg_q.motor_reversed <= cfg_data[0];
				REG_MIN_WINDOW:     cfg_q.min_window_us  <= cfg_data;
				REG_MAX_WINDOW:     cfg_q.max_window_us  <= cfg_data;
				REG_SPEED_SCALE:    cfg_q.speed_scale    <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== design/hem_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall encoder RPM meter divider
// Restoring divider that produces one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module hem_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [hem_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [hem_pkg::DIVISOR_W-1:0]   divisor,
	output logic                            done,
	output logic [hem_pkg::DIVIDEND_W-1:0]  quotient
);
	import hem_pkg::*;

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  div_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	// Bring down the next dividend bit and try one subtraction.
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

endmodule

// ===== design/hem_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hall encoder RPM meter checker
// Port-level assertions on the meter's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module hem_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic cfg_valid,
	input logic cfg_ready
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// The block is busy right after taking an event.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("event taken without going busy");

	// A new result only appears as the sequencer finishes an event.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while idle");

	// The configuration port never blocks a write.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write blocked");

endmodule

bind hall_encoder_rpm_meter_top hem_checker u_hem_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
